// File: rtl/tvs_pkg.sv
// Shared types, codes and constants of the tagged value serializer.
// No dependencies; every rtl file refers to it by scoped names.
package tvs_pkg;

    localparam int POS_W  = 17;   // write position, capacity, end position
    localparam int OFF_W  = 16;   // byte offset field
    localparam int VAL_W  = 64;   // value field
    localparam int CNT_W  = 4;    // bytes per item, up to eleven

    // Largest usable capacity; a register value above it acts as it.
    localparam logic [32:0] MAX_CAPACITY = 33'd65536;
    localparam logic [POS_W-1:0] CAP_LIMIT =
        (MAX_CAPACITY > 33'h1FFFF) ? {POS_W{1'b1}} : MAX_CAPACITY[POS_W-1:0];
    localparam logic [POS_W-1:0] CAP_RESET = 17'd65536;

    localparam logic [3:0] NIBBLE_ESCAPE = 4'hF;   // vector length follows as ULEB128
    localparam logic [3:0] FIXED_MAX     = 4'd8;

    typedef enum logic [2:0] {
        REQ_FIXED   = 3'd0,
        REQ_ULEB    = 3'd1,
        REQ_SLEB    = 3'd2,
        REQ_SHORT   = 3'd3,
        REQ_VECTOR  = 3'd4,
        REQ_END     = 3'd5,
        REQ_RESTART = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CAPACITY = 2'd1,
        ERR_SHORT    = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_ULEB = 2'd1,
        MODE_SLEB = 2'd2
    } digit_mode_t;

    typedef struct packed {
        logic        load;
        logic        rewind;
        logic        step;
        digit_mode_t mode;
    } shift_ctrl_t;

    typedef struct packed {
        logic [7:0] digit;
        logic       more;
    } shift_stat_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic [OFF_W-1:0] byte_offset;
        logic             last_byte;
        err_t             error_code;
        logic [POS_W-1:0] end_position;
    } result_t;

endpackage

// File: rtl/tagged_value_serializer.sv
// Top level of the tagged value serializer: sequencer, capacity check and ports.
// Depends on tvs_pkg, tvs_digit_shift and tvs_out_stage.
//
//  channel   direction  payload
//  s_axis    in         tuser: req_type[2:0]; tdata: header_type, fixed_bytes, data_value
//  m_axis    out        tuser: byte_valid, error_code; tdata: out_byte, byte_offset,
//                       end_position; tlast: last_byte
//  cfg       in         cfg_wr_data: buffer_capacity, written when cfg_wr_en is high
//
// Sequence: an accepted item goes through S_DECODE, S_MEASURE (LEB128 payloads
// only, whose digits are counted one per cycle in the value shift register),
// the capacity check in S_CHECK, then S_HEADER and S_BODY until the next
// s_axis_tready. One result leaves per cycle while m_axis_tready is high; the
// output register is the limit on emission. A capacity error or a short value
// above 15 ends in S_ERROR; restart and the unused code return to S_IDLE.
// Reset (aresetn low at a clock edge) clears the write position, restores the
// capacity to 65536 and empties the output register.
// A stalled m_axis holds the sequencer in place; s_axis_tready is high only
// between items.
module tagged_value_serializer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input transactions
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [71:0]                 s_axis_tdata,   // header_type[3:0], fixed_bytes[7:4],
                                                        // data_value[71:8]
    input  logic [2:0]                  s_axis_tuser,   // req_type[2:0]
    // result transactions
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,   // out_byte[7:0], byte_offset[23:8],
                                                        // end_position[40:24], zero above
    output logic [2:0]                  m_axis_tuser,   // byte_valid[0], error_code[2:1]
    output logic                        m_axis_tlast,   // last_byte
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [tvs_pkg::POS_W-1:0]   cfg_wr_data     // buffer_capacity
);

    // one-hot sequencer
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_MEASURE = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_HEADER  = 7'b0010000,
        S_BODY    = 7'b0100000,
        S_ERROR   = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [tvs_pkg::POS_W-1:0]     cap_reg, cap_next;
    logic [tvs_pkg::POS_W-1:0]     wp_reg, wp_next;      // write position
    logic [tvs_pkg::POS_W-1:0]     off_reg, off_next;    // offset of the next byte
    logic [tvs_pkg::POS_W-1:0]     end_reg, end_next;    // position after this item
    tvs_pkg::req_t                 req_reg, req_next;
    logic [3:0]                    type_reg, type_next;
    logic [tvs_pkg::CNT_W-1:0]     nfix_reg, nfix_next;
    logic [tvs_pkg::CNT_W-1:0]     n_reg, n_next;        // bytes in the item
    logic [tvs_pkg::CNT_W-1:0]     rem_reg, rem_next;    // payload bytes still to send
    logic [7:0]                    hdr_reg, hdr_next;
    logic                          skip_reg, skip_next;  // vector: value is skipped space
    tvs_pkg::err_t                 err_reg, err_next;
    tvs_pkg::digit_mode_t          mode_reg, mode_next;

    tvs_pkg::shift_ctrl_t          sh_ctrl;
    tvs_pkg::shift_stat_t          sh_stat;
    logic [tvs_pkg::VAL_W-1:0]     sv;

    logic                          out_space, push;
    tvs_pkg::result_t              res, m_res;

    logic                          s_acc;
    logic [3:0]                    in_nfix;

    // capacity check terms
    logic [tvs_pkg::POS_W-1:0]     cap_eff, avail;
    logic [tvs_pkg::POS_W:0]       need;
    logic                          over, skip_hi, fits;
    logic                          val_small, val_lt15;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_nfix       = s_axis_tdata[7:4];

    assign val_small = ~|sv[tvs_pkg::VAL_W-1:4];
    assign val_lt15  = val_small && (sv[3:0] != tvs_pkg::NIBBLE_ESCAPE);

    always_comb begin
        cap_eff = (cap_reg > tvs_pkg::CAP_LIMIT) ? tvs_pkg::CAP_LIMIT : cap_reg;
        over    = wp_reg > cap_eff;
        avail   = cap_eff - wp_reg;
        skip_hi = skip_reg && (|sv[tvs_pkg::VAL_W-1:tvs_pkg::POS_W]);
        need    = {{(tvs_pkg::POS_W + 1 - tvs_pkg::CNT_W){1'b0}}, n_reg}
                + (skip_reg ? {1'b0, sv[tvs_pkg::POS_W-1:0]} : '0);
        fits    = !over && !skip_hi && (need <= {1'b0, avail});
    end

    tvs_digit_shift u_shift (
        .aclk        (aclk),
        .ctrl        (sh_ctrl),
        .load_value  (s_axis_tdata[71:8]),
        .stat        (sh_stat),
        .saved_value (sv)
    );

    // result of the current emitting state
    always_comb begin
        res.out_byte     = hdr_reg;
        res.byte_valid   = 1'b1;
        res.byte_offset  = off_reg[tvs_pkg::OFF_W-1:0];
        res.last_byte    = (n_reg == tvs_pkg::CNT_W'(1));
        res.error_code   = tvs_pkg::ERR_NONE;
        res.end_position = end_reg;
        case (state_reg)
            S_BODY: begin
                res.out_byte  = sh_stat.digit;
                res.last_byte = (rem_reg == tvs_pkg::CNT_W'(1));
            end
            S_ERROR: begin
                res.out_byte     = 8'd0;
                res.byte_valid   = 1'b0;
                res.byte_offset  = wp_reg[tvs_pkg::OFF_W-1:0];
                res.last_byte    = 1'b1;
                res.error_code   = err_reg;
                res.end_position = wp_reg;
            end
            default: begin
            end
        endcase
    end

    assign push = out_space && (state_reg inside {S_HEADER, S_BODY, S_ERROR});

    always_comb begin
        sh_ctrl.load   = s_acc;
        sh_ctrl.rewind = (state_reg == S_MEASURE) && !sh_stat.more;
        sh_ctrl.step   = ((state_reg == S_MEASURE) && sh_stat.more)
                      || ((state_reg == S_BODY) && push);
        sh_ctrl.mode   = mode_reg;
    end

    always_comb begin
        state_next = state_reg;
        cap_next   = cap_reg;
        wp_next    = wp_reg;
        off_next   = off_reg;
        end_next   = end_reg;
        req_next   = req_reg;
        type_next  = type_reg;
        nfix_next  = nfix_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        hdr_next   = hdr_reg;
        skip_next  = skip_reg;
        err_next   = err_reg;
        mode_next  = mode_reg;

        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    req_next  = tvs_pkg::req_t'(s_axis_tuser);
                    type_next = s_axis_tdata[3:0];
                    // count 0 acts as 1, above 8 as 8
                    if (in_nfix == 4'd0) begin
                        nfix_next = 4'd1;
                    end else if (in_nfix > tvs_pkg::FIXED_MAX) begin
                        nfix_next = tvs_pkg::FIXED_MAX;
                    end else begin
                        nfix_next = in_nfix;
                    end
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                n_next     = tvs_pkg::CNT_W'(1);
                hdr_next   = {4'h0, type_reg};
                skip_next  = 1'b0;
                mode_next  = tvs_pkg::MODE_RAW;
                state_next = S_CHECK;
                case (req_reg)
                    tvs_pkg::REQ_FIXED: begin
                        n_next = nfix_reg + tvs_pkg::CNT_W'(1);
                    end
                    tvs_pkg::REQ_ULEB: begin
                        mode_next  = tvs_pkg::MODE_ULEB;
                        state_next = S_MEASURE;
                    end
                    tvs_pkg::REQ_SLEB: begin
                        mode_next  = tvs_pkg::MODE_SLEB;
                        state_next = S_MEASURE;
                    end
                    tvs_pkg::REQ_SHORT: begin
                        hdr_next = {sv[3:0], type_reg};
                        if (!val_small) begin
                            err_next   = tvs_pkg::ERR_SHORT;
                            state_next = S_ERROR;
                        end
                    end
                    tvs_pkg::REQ_VECTOR: begin
                        skip_next = 1'b1;
                        if (val_lt15) begin
                            hdr_next = {sv[3:0], type_reg};
                        end else begin
                            hdr_next   = {tvs_pkg::NIBBLE_ESCAPE, type_reg};
                            mode_next  = tvs_pkg::MODE_ULEB;
                            state_next = S_MEASURE;
                        end
                    end
                    tvs_pkg::REQ_END: begin
                    end
                    tvs_pkg::REQ_RESTART: begin
                        wp_next    = '0;
                        state_next = S_IDLE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MEASURE: begin
                // one LEB128 digit counted per cycle, shifter rewound at the end
                n_next = n_reg + tvs_pkg::CNT_W'(1);
                if (!sh_stat.more) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (fits) begin
                    off_next   = wp_reg;
                    end_next   = wp_reg + need[tvs_pkg::POS_W-1:0];
                    rem_next   = n_reg - tvs_pkg::CNT_W'(1);
                    state_next = S_HEADER;
                end else begin
                    err_next   = tvs_pkg::ERR_CAPACITY;
                    state_next = S_ERROR;
                end
            end
            S_HEADER: begin
                if (push) begin
                    off_next = off_reg + tvs_pkg::POS_W'(1);
                    if (n_reg == tvs_pkg::CNT_W'(1)) begin
                        wp_next    = end_reg;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (push) begin
                    off_next = off_reg + tvs_pkg::POS_W'(1);
                    rem_next = rem_reg - tvs_pkg::CNT_W'(1);
                    if (rem_reg == tvs_pkg::CNT_W'(1)) begin
                        wp_next    = end_reg;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERROR: begin
                if (push) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg   <= tvs_pkg::CAP_RESET;
            wp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            wp_reg    <= wp_next;
        end
        off_reg  <= off_next;
        end_reg  <= end_next;
        req_reg  <= req_next;
        type_reg <= type_next;
        nfix_reg <= nfix_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        hdr_reg  <= hdr_next;
        skip_reg <= skip_next;
        err_reg  <= err_next;
        mode_reg <= mode_next;
    end

    tvs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .space     (out_space),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_res)
    );

    assign m_axis_tdata = {7'd0, m_res.end_position, m_res.byte_offset, m_res.out_byte};
    assign m_axis_tuser = {m_res.error_code, m_res.byte_valid};
    assign m_axis_tlast = m_res.last_byte;

    // bytes being sent always lie before the item's end position
    a_off_before_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HEADER || state_reg == S_BODY) |-> (off_reg < end_reg))
        else $error("byte offset reached end position");

    // an item never exceeds header plus ten LEB128 digits
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEASURE || state_reg == S_CHECK) |-> (n_reg <= tvs_pkg::CNT_W'(11)))
        else $error("byte count overrun");

    // within an item, offsets of consecutive bytes step by one
    a_offset_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid ||
         (m_axis_tdata[23:8] == $past(m_axis_tdata[23:8]) + 16'd1)))
        else $error("byte offsets not consecutive");

    // an error transaction is the only result of its item
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("error transaction not marked last");

endmodule

// File: rtl/tvs_digit_shift.sv
// Value shift register: yields one raw byte or one LEB128 digit per step.
// Keeps a copy of the loaded value so that a measuring pass can be undone.
// Depends on tvs_pkg.
module tvs_digit_shift (
    input  logic                            aclk,
    input  tvs_pkg::shift_ctrl_t            ctrl,
    input  logic [tvs_pkg::VAL_W-1:0]       load_value,
    output tvs_pkg::shift_stat_t            stat,
    output logic [tvs_pkg::VAL_W-1:0]       saved_value
);

    logic [tvs_pkg::VAL_W-1:0] value_reg, value_next;
    logic [tvs_pkg::VAL_W-1:0] saved_reg, saved_next;
    logic [tvs_pkg::VAL_W-1:0] shifted;
    logic                      more;

    always_comb begin
        shifted = {8'd0, value_reg[tvs_pkg::VAL_W-1:8]};
        more    = |shifted;
        case (ctrl.mode)
            tvs_pkg::MODE_RAW: begin
                shifted = {8'd0, value_reg[tvs_pkg::VAL_W-1:8]};
                more    = |shifted;
            end
            tvs_pkg::MODE_ULEB: begin
                shifted = {7'd0, value_reg[tvs_pkg::VAL_W-1:7]};
                more    = |shifted;
            end
            tvs_pkg::MODE_SLEB: begin
                shifted = {{7{value_reg[tvs_pkg::VAL_W-1]}}, value_reg[tvs_pkg::VAL_W-1:7]};
                // stop once the rest is pure sign and bit 6 agrees with it
                more    = !(((~|shifted) && !value_reg[6]) || ((&shifted) && value_reg[6]));
            end
            default: begin
                shifted = {8'd0, value_reg[tvs_pkg::VAL_W-1:8]};
                more    = |shifted;
            end
        endcase
    end

    always_comb begin
        stat.more  = more;
        stat.digit = (ctrl.mode == tvs_pkg::MODE_RAW) ? value_reg[7:0]
                                                      : {more, value_reg[6:0]};
    end

    always_comb begin
        value_next = value_reg;
        saved_next = saved_reg;
        if (ctrl.load) begin
            value_next = load_value;
            saved_next = load_value;
        end else if (ctrl.rewind) begin
            value_next = saved_reg;
        end else if (ctrl.step) begin
            value_next = shifted;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        saved_reg <= saved_next;
    end

    assign saved_value = saved_reg;

endmodule

// File: rtl/tvs_out_stage.sv
// Output register of the result channel; takes a new result when empty
// or when the held one leaves in the same cycle. Depends on tvs_pkg.
module tvs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tvs_pkg::result_t  push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output tvs_pkg::result_t  m_data
);

    logic             valid_reg, valid_next;
    tvs_pkg::result_t data_reg, data_next;

    assign space = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (push) begin
            valid_next = 1'b1;
            data_next  = push_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: test/tvs_checker.sv
// Passive checker for tagged_value_serializer: watches both streams and the
// capacity port, predicts every output byte and compares. Depends on tvs_pkg.
module tvs_checker
    import tvs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [71:0]       s_axis_tdata,
    input  logic [2:0]        s_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [47:0]       m_axis_tdata,
    input  logic [2:0]        m_axis_tuser,
    input  logic              m_axis_tlast,
    input  logic              cfg_wr_en,
    input  logic [POS_W-1:0]  cfg_wr_data,
    output int                owed_count,
    output int                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    result_t           owed_bytes[$];   // bytes the block still has to deliver
    logic [POS_W-1:0]  write_pos;
    logic [POS_W-1:0]  capacity;
    int                errors;

    task automatic post_error(input err_t code);
        result_t r;
        r.out_byte     = '0;
        r.byte_valid   = 1'b0;
        r.byte_offset  = write_pos[OFF_W-1:0];
        r.last_byte    = 1'b1;
        r.error_code   = code;
        r.end_position = write_pos;
        owed_bytes.push_back(r);
    endtask

    task automatic serialize_item(input req_t req, input logic [3:0] htype,
                                  input logic [3:0] nfix_in, input logic [63:0] val);
        logic [7:0]         enc [11];
        int                 n;
        int                 nfix;
        digit_mode_t        mode;     // MODE_RAW unless varint digits follow
        logic [63:0]        skip;
        logic [63:0]        cap;
        logic [63:0]        endp;
        logic signed [63:0] sv;
        logic [7:0]         b;
        logic               more;
        result_t            r;
        n    = 0;
        skip = '0;
        mode = MODE_RAW;
        cap  = (capacity > CAP_LIMIT) ? 64'(CAP_LIMIT) : 64'(capacity);
        case (req)
            REQ_FIXED: begin
                nfix = (nfix_in == 0) ? 1 : (nfix_in > FIXED_MAX) ? int'(FIXED_MAX) : nfix_in;
                enc[n] = {4'h0, htype};
                n++;
                for (int i = 0; i < nfix; i++) begin
                    enc[n] = val[8*i +: 8];
                    n++;
                end
            end
            REQ_ULEB, REQ_SLEB: begin
                enc[n] = {4'h0, htype};
                n++;
                mode = (req == REQ_ULEB) ? MODE_ULEB : MODE_SLEB;
            end
            REQ_SHORT: begin
                if (val > 64'd15) begin
                    post_error(ERR_SHORT);
                    return;
                end
                enc[n] = {val[3:0], htype};
                n++;
            end
            REQ_VECTOR: begin
                if (val < 64'd15) begin
                    enc[n] = {val[3:0], htype};
                end else begin
                    enc[n] = {NIBBLE_ESCAPE, htype};
                    mode = MODE_ULEB;
                end
                n++;
                skip = val;
            end
            REQ_END: begin
                enc[n] = {4'h0, htype};
                n++;
            end
            REQ_RESTART: begin
                write_pos = '0;
                return;
            end
            default: return;   // unused code: no bytes, no state change
        endcase

        // LEB128 digits, seven bits each, low group first
        if (mode != MODE_RAW) begin
            sv = val;
            do begin
                b = {1'b0, sv[6:0]};
                if (mode == MODE_SLEB) begin
                    sv   = sv >>> 7;
                    more = !((sv == 0 && !b[6]) || ((&sv) && b[6]));
                end else begin
                    sv   = sv >> 7;
                    more = (sv != 0);
                end
                if (more) b[7] = 1'b1;
                enc[n] = b;
                n++;
            end while (more);
        end

        // header, digits and skipped vector space must all fit
        if (64'(write_pos) > cap || 64'(n) > cap - write_pos ||
            skip > cap - write_pos - 64'(n)) begin
            post_error(ERR_CAPACITY);
            return;
        end
        endp = 64'(write_pos) + 64'(n) + skip;
        for (int i = 0; i < n; i++) begin
            r.out_byte     = enc[i];
            r.byte_valid   = 1'b1;
            r.byte_offset  = OFF_W'(write_pos + POS_W'(i));
            r.last_byte    = (i == n - 1);
            r.error_code   = ERR_NONE;
            r.end_position = endp[POS_W-1:0];
            owed_bytes.push_back(r);
        end
        write_pos = endp[POS_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        result_t want;
        result_t got;
        got.out_byte     = m_axis_tdata[7:0];
        got.byte_offset  = m_axis_tdata[23:8];
        got.end_position = m_axis_tdata[40:24];
        got.byte_valid   = m_axis_tuser[0];
        got.error_code   = err_t'(m_axis_tuser[2:1]);
        got.last_byte    = m_axis_tlast;
        if (owed_bytes.size() == 0) begin
            $display("%0t: result expected none actual byte %0h offset %0h err %0d",
                     $time, got.out_byte, got.byte_offset, got.error_code);
            errors++;
            return;
        end
        want = owed_bytes.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("byte_offset", want.byte_offset, got.byte_offset);
        check_field("last_byte", want.last_byte, got.last_byte);
        check_field("error_code", want.error_code, got.error_code);
        check_field("end_position", want.end_position, got.end_position);
    endtask

    initial begin
        errors     = 0;
        fail_count = 0;
        owed_count = 0;
        write_pos  = '0;
        capacity   = CAP_RESET;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            write_pos = '0;
            capacity  = CAP_RESET;
            owed_bytes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                serialize_item(req_t'(s_axis_tuser), s_axis_tdata[3:0],
                               s_axis_tdata[7:4], s_axis_tdata[71:8]);
            if (cfg_wr_en)
                capacity = cfg_wr_data;
        end
        owed_count <= owed_bytes.size();
        fail_count <= errors;
    end

endmodule

// File: test/tb.sv
// Testbench top for tagged_value_serializer: clock, reset, stimulus and verdict.
// Depends on tvs_pkg, the block itself and tvs_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tvs_pkg::*;

    localparam logic [2:0] REQ_UNUSED   = 3'd7;   // request code the block ignores
    localparam int  PHASE_ITEMS    = 45;
    localparam int  NUM_PHASES     = 7;
    localparam int  DRAIN_CYCLES   = 20;          // covers error, restart and ignored codes
    localparam int  WATCHDOG_LIMIT = 1000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata;
    logic [2:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              cfg_wr_en;
    logic [POS_W-1:0]  cfg_wr_data;

    int                owed_count;
    int                fail_count;
    int                quiet_cycles;
    bit                tx_gaps;      // sender idles between transactions
    bit                rx_stalls;    // receiver holds tready low before transactions

    always #1 aclk = ~aclk;

    tagged_value_serializer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    tvs_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .owed_count    (owed_count),
        .fail_count    (fail_count)
    );

    // Watchdog: any stretch without a transaction on either stream this long
    // means the block has hung (or owes bytes it never sends).
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: before each transaction draw a random stall with tready low. A zero
    // draw leaves tready high, so back-to-back bytes flow without a gap.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = rx_stalls ? $urandom_range(0, 16) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // One input transaction: optional gap with tvalid low, then hold the item
    // until the block takes it. tvalid stays high into the next item when
    // that one draws no gap.
    task automatic send_item(input logic [2:0] req, input logic [3:0] htype,
                             input logic [3:0] nfix, input logic [63:0] val);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {val, nfix, htype};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Sender stops until every owed byte is out, then lets the block settle
    // (restart and ignored codes leave it busy with nothing owed).
    task automatic wait_idle();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (owed_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [POS_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand_bits(input int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (w >= 64) ? r : (r & ((64'd1 << w) - 64'd1));
    endfunction

    // two's complement value that needs w bits, sign extended to 64
    function automatic logic [63:0] rand_signed(input int w);
        logic signed [63:0] s;
        s = {$urandom, $urandom};
        s = s << (64 - w);
        return s >>> (64 - w);
    endfunction

    // Random mix: mostly writing items, a few restarts to keep room in the
    // buffer, and a sprinkle of the unused code. counted is low for the
    // unused code since the block ignores it.
    task automatic send_random_item(output bit counted);
        int          pick;
        logic [2:0]  req;
        logic [3:0]  htype;
        logic [3:0]  nfix;
        logic [63:0] val;
        pick  = $urandom_range(0, 99);
        htype = 4'($urandom);
        nfix  = 4'($urandom);
        val   = {$urandom, $urandom};
        if (pick < 20) begin
            req = REQ_FIXED;
        end else if (pick < 38) begin
            req = REQ_ULEB;
            val = rand_bits($urandom_range(0, 64));
        end else if (pick < 56) begin
            req = REQ_SLEB;
            val = rand_signed($urandom_range(1, 64));
        end else if (pick < 68) begin
            req = REQ_SHORT;
            if ($urandom_range(0, 4) != 0) val = 64'($urandom_range(0, 15));
        end else if (pick < 82) begin
            req = REQ_VECTOR;
            case ($urandom_range(0, 9))
                0:       ;                                   // huge length, overflow
                1, 2:    val = 64'($urandom_range(15, 400)); // escaped length
                default: val = 64'($urandom_range(0, 20));
            endcase
        end else if (pick < 90) begin
            req = REQ_END;
        end else if (pick < 95) begin
            req = REQ_RESTART;
        end else begin
            req = REQ_UNUSED;
        end
        send_item(req, htype, nfix, val);
        counted = (req != REQ_UNUSED);
    endtask

    initial begin
        logic [POS_W-1:0] phase_cap [NUM_PHASES];
        int  sent;
        bit  counted;
        phase_cap = '{17'h1FFFF, 17'd0, 17'd24, CAP_RESET, 17'd0, 17'd300, CAP_RESET};

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        aresetn       = 1'b0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;

        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed: capacity at its reset value.
        // fixed counts: zero acts as one, nine and up act as eight
        send_item(REQ_FIXED, 4'h0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_FIXED, 4'hF, 4'd1, 64'h0);
        send_item(REQ_FIXED, 4'h5, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_item(REQ_FIXED, 4'hA, 4'd15, 64'hFEDC_BA98_7654_3210);
        // ULEB128 digit boundaries, all ones gives the longest item
        send_item(REQ_ULEB, 4'h1, 4'd0, 64'd0);
        send_item(REQ_ULEB, 4'h1, 4'd0, 64'd127);
        send_item(REQ_ULEB, 4'h1, 4'd0, 64'd128);
        send_item(REQ_ULEB, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        // SLEB128 sign boundaries and the most negative value
        send_item(REQ_SLEB, 4'h2, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(REQ_SLEB, 4'h2, 4'd0, 64'd63);
        send_item(REQ_SLEB, 4'h2, 4'd0, 64'd64);
        send_item(REQ_SLEB, 4'h2, 4'd0, -64'sd65);
        send_item(REQ_SLEB, 4'h2, 4'd0, 64'h8000_0000_0000_0000);
        // short values; above fifteen is an error, even with only the top bit set
        send_item(REQ_SHORT, 4'h3, 4'd0, 64'd0);
        send_item(REQ_SHORT, 4'h3, 4'd0, 64'd15);
        send_item(REQ_SHORT, 4'h3, 4'd0, 64'd16);
        send_item(REQ_SHORT, 4'h3, 4'd0, 64'h8000_0000_0000_0000);
        // vector lengths in the nibble, then escaped
        send_item(REQ_VECTOR, 4'h4, 4'd0, 64'd0);
        send_item(REQ_VECTOR, 4'h4, 4'd0, 64'd14);
        send_item(REQ_VECTOR, 4'h4, 4'd0, 64'd15);
        send_item(REQ_VECTOR, 4'h4, 4'd0, 64'd300);
        send_item(REQ_END, 4'hE, 4'd0, 64'd0);
        send_item(REQ_UNUSED, 4'h7, 4'd7, 64'd7);
        // fill exactly to the capacity: vector skip, one fixed byte pair,
        // then everything overflows, huge lengths included
        send_item(REQ_RESTART, 4'h0, 4'd0, 64'd0);
        send_item(REQ_VECTOR, 4'h9, 4'd0, 64'd65530);
        send_item(REQ_FIXED, 4'h6, 4'd1, 64'hA5);
        send_item(REQ_END, 4'hE, 4'd0, 64'd0);
        send_item(REQ_VECTOR, 4'h9, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);

        // lowered capacity below the current position: errors until restart
        write_capacity(17'd100);
        send_item(REQ_FIXED, 4'h1, 4'd2, 64'h1234);
        send_item(REQ_ULEB, 4'h1, 4'd0, 64'd5);
        send_item(REQ_RESTART, 4'h0, 4'd0, 64'd0);
        send_item(REQ_FIXED, 4'h1, 4'd2, 64'h1234);

        // Random phases over several capacities, each with one of four idling mixes;
        // the idle wait before every write also drains the block completely.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 4) phase_cap[phase] = POS_W'($urandom_range(0, 17'h1FFFF));
            write_capacity(phase_cap[phase]);
            tx_gaps   = (phase % 4 == 0) || (phase % 4 == 2);
            rx_stalls = (phase % 4 == 0) || (phase % 4 == 1);
            if ($urandom_range(0, 1) != 0)
                send_item(REQ_RESTART, 4'h0, 4'd0, 64'd0);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_item(counted);
                if (counted) sent++;
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: tagged_value_serializer.f
rtl/tvs_pkg.sv
rtl/tvs_digit_shift.sv
rtl/tvs_out_stage.sv
rtl/tagged_value_serializer.sv
test/tvs_checker.sv
test/tb.sv
